[hdl/bsu_pkg.sv]
// shared types, codes and field widths of the breakpoint and step unit
package bsu_pkg;

    localparam int SOURCE_BITS = 16;
    localparam int LINE_BITS   = 20;
    localparam int DEPTH_BITS  = 8;
    localparam int OP_BITS     = 4;
    localparam int SLOT_BITS   = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_EVENT      = 4'd0,
        OP_SET_BP     = 4'd1,
        OP_CLEAR_BP   = 4'd2,
        OP_CLEAR_ALL  = 4'd3,
        OP_STEP_OVER  = 4'd4,
        OP_STEP_INTO  = 4'd5,
        OP_STEP_OUT   = 4'd6,
        OP_CONTINUE   = 4'd7,
        OP_PAUSE      = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SLOT = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_BITS-1:0]     operation;
        logic                   location_valid;
        logic [SOURCE_BITS-1:0] file_id;
        logic [LINE_BITS-1:0]   line;
        logic [DEPTH_BITS-1:0]  frame_depth;
        logic [SLOT_BITS-1:0]   slot;
    } t_in_word;

    typedef struct packed {
        logic                 stop;
        logic                 stop_reason;
        logic [1:0]           status;
        logic [SLOT_BITS-1:0] slot_id;
        logic                 paused;
    } t_out_word;

    // requests to the breakpoint table, already qualified by the item advancing
    typedef struct packed {
        logic                   set;
        logic                   clear;
        logic                   clear_all;
        logic [SLOT_BITS-1:0]   slot;
        logic [SOURCE_BITS-1:0] source;
        logic [LINE_BITS-1:0]   line;
    } t_tbl_cmd;

    typedef struct packed {
        logic                 hit;
        t_status              status;
        logic [SLOT_BITS-1:0] slot_id;
    } t_tbl_rsp;

    typedef struct packed {
        logic stop;
        logic reason;
        logic paused;
    } t_mode_rsp;

endpackage

[hdl/breakpoint_and_step_unit.sv]
// top level of the breakpoint and single-step unit
//
//  channel  | valid        | ready        | word                  | direction
//  ---------+--------------+--------------+-----------------------+----------
//  input    | i_in_valid   | o_in_ready   | i_in_word  (t_in_word)  | in
//  result   | o_out_valid  | i_out_ready  | o_out_word (t_out_word) | out
//
// one result word per input word, one word per cycle sustained while i_out_ready is high
// each word passes the input register, then the table and mode logic into the result register
// the table match and free-slot search are parallel compares over all slots
// synchronous active-low reset clears the table marks, fill count, mode and flags
// a stalled result holds its word; the input register keeps taking words until
// both it and the result register are full
module breakpoint_and_step_unit #(
    parameter int BREAKPOINT_SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsu_pkg::t_out_word o_out_word
);
    import bsu_pkg::*;

    // input stage
    logic     r_in_vld;
    t_in_word r_in;

    // result stage
    logic      r_out_vld;
    t_out_word r_out, n_out;

    logic      adv;        // word in the input register is processed this cycle
    logic      in_take;
    t_tbl_cmd  tbl_cmd;
    t_tbl_rsp  tbl_rsp;
    t_mode_rsp mode_rsp;

    // the result register frees up when empty or being drained
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_take    = i_in_valid && o_in_ready;

    // table requests are only raised for the word that advances
    always_comb begin
        tbl_cmd.set       = adv && (r_in.operation == OP_SET_BP);
        tbl_cmd.clear     = adv && (r_in.operation == OP_CLEAR_BP);
        tbl_cmd.clear_all = adv && (r_in.operation == OP_CLEAR_ALL);
        tbl_cmd.slot      = r_in.slot;
        tbl_cmd.source    = r_in.file_id;
        tbl_cmd.line      = r_in.line;
    end

    bsu_bp_table #(
        .SLOTS (BREAKPOINT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    bsu_mode_ctrl u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apply  (adv),
        .i_word   (r_in),
        .i_bp_hit (tbl_rsp.hit),
        .o_rsp    (mode_rsp)
    );

    // merge table status and stop decision into one result word
    always_comb begin
        n_out.stop        = mode_rsp.stop;
        n_out.stop_reason = mode_rsp.reason;
        n_out.status      = tbl_rsp.status;
        n_out.slot_id     = tbl_rsp.slot_id;
        n_out.paused      = mode_rsp.paused;
    end

    // handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("processed word did not reach the result register");

    a_stop_has_paused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.stop) |-> (r_out.paused && r_out.status == ST_OK))
        else $error("stop result without paused flag or with error status");

    a_no_reason_without_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.stop) |-> !r_out.stop_reason)
        else $error("stop reason set without a stop");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost a waiting word");

endmodule

[hdl/bsu_bp_table.sv]
// breakpoint slot table: storage, parallel match and first-free slot search
module bsu_bp_table #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsu_pkg::t_tbl_cmd i_cmd,
    output bsu_pkg::t_tbl_rsp o_rsp
);
    import bsu_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > SLOT_BITS) ? CNT_W : SLOT_BITS;

    logic [SOURCE_BITS-1:0] r_src  [SLOTS];
    logic [LINE_BITS-1:0]   r_line [SLOTS];
    logic [SLOTS-1:0]       r_active, n_active;
    logic [CNT_W-1:0]       r_used, n_used;

    logic [SLOTS-1:0]  used_mask, hit_vec, free_vec, wr_vec;
    logic              found, room, do_set, clr_ok;
    logic [SLOT_W-1:0] free_idx, wr_idx;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            used_mask[i] = CNT_W'(i) < r_used;
            hit_vec[i]   = r_active[i] && (r_src[i] == i_cmd.source)
                           && (r_line[i] == i_cmd.line);
            free_vec[i]  = used_mask[i] && !r_active[i];
        end
        // lowest inactive slot in use wins
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        room   = r_used < CNT_W'(SLOTS);
        wr_idx = found ? free_idx : r_used[SLOT_W-1:0];
        do_set = i_cmd.set && (found || room);
        clr_ok = CMP_W'(i_cmd.slot) < CMP_W'(r_used);

        for (int i = 0; i < SLOTS; i++) begin
            wr_vec[i] = do_set && (wr_idx == SLOT_W'(i));
        end

        n_active = r_active | wr_vec;
        if (i_cmd.clear_all) begin
            n_active = '0;
        end
        if (i_cmd.clear && clr_ok) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (CMP_W'(i) == CMP_W'(i_cmd.slot)) begin
                    n_active[i] = 1'b0;
                end
            end
        end
        n_used = (do_set && !found) ? r_used + CNT_W'(1) : r_used;

        o_rsp.hit     = |hit_vec;
        o_rsp.slot_id = do_set ? SLOT_BITS'(wr_idx) : '0;
        if (i_cmd.set && !do_set) begin
            o_rsp.status = ST_FULL;
        end else if (i_cmd.clear && !clr_ok) begin
            o_rsp.status = ST_BAD_SLOT;
        end else begin
            o_rsp.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_used   <= '0;
        end else begin
            r_active <= n_active;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (wr_vec[i]) begin
                r_src[i]  <= i_cmd.source;
                r_line[i] <= i_cmd.line;
            end
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOTS))
        else $error("breakpoint fill count beyond table size");

    a_active_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~used_mask) == '0)
        else $error("active breakpoint above fill count");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set && o_rsp.status == ST_FULL) |-> (r_used == CNT_W'(SLOTS) && !found))
        else $error("table full reported with a slot free");

endmodule

[hdl/bsu_mode_ctrl.sv]
// run mode, step origin and paused flag, with the per-event stop decision
module bsu_mode_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_apply,
    input  bsu_pkg::t_in_word  i_word,
    input  logic               i_bp_hit,
    output bsu_pkg::t_mode_rsp o_rsp
);
    import bsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_RUN       = 3'd0,
        MODE_PAUSE     = 3'd1,
        MODE_STEP_OVER = 3'd2,
        MODE_STEP_INTO = 3'd3,
        MODE_STEP_OUT  = 3'd4
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [DEPTH_BITS-1:0]  r_depth, n_depth;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [SOURCE_BITS-1:0] r_src, n_src;
    logic                   r_paused, n_paused;

    logic moved, mode_hit, stop;

    always_comb begin
        moved = (i_word.file_id != r_src) || (i_word.line != r_line);
        case (r_mode)
            MODE_RUN:       mode_hit = 1'b0;
            MODE_PAUSE:     mode_hit = 1'b1;
            MODE_STEP_INTO: mode_hit = moved;
            MODE_STEP_OVER: mode_hit = moved && (i_word.frame_depth <= r_depth);
            MODE_STEP_OUT:  mode_hit = i_word.frame_depth < r_depth;
            default:        mode_hit = 1'b0;
        endcase

        stop     = 1'b0;
        n_mode   = r_mode;
        n_depth  = r_depth;
        n_line   = r_line;
        n_src    = r_src;
        n_paused = r_paused;

        case (i_word.operation)
            OP_EVENT: begin
                stop = i_word.location_valid && (mode_hit || i_bp_hit);
                if (stop) begin
                    n_paused = 1'b1;
                end
            end
            OP_STEP_OVER, OP_STEP_INTO, OP_STEP_OUT: begin
                case (i_word.operation)
                    OP_STEP_OVER: n_mode = MODE_STEP_OVER;
                    OP_STEP_INTO: n_mode = MODE_STEP_INTO;
                    default:      n_mode = MODE_STEP_OUT;
                endcase
                n_depth  = i_word.frame_depth;
                n_src    = i_word.location_valid ? i_word.file_id : '0;
                n_line   = i_word.location_valid ? i_word.line : '0;
                n_paused = 1'b0;
            end
            OP_CONTINUE: begin
                n_mode   = MODE_RUN;
                n_paused = 1'b0;
            end
            OP_PAUSE: begin
                n_mode = MODE_PAUSE;
            end
            default: begin
            end
        endcase

        o_rsp.stop   = stop;
        o_rsp.reason = stop && (r_mode != MODE_RUN);
        o_rsp.paused = n_paused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RUN;
            r_depth  <= '0;
            r_line   <= '0;
            r_src    <= '0;
            r_paused <= 1'b0;
        end else if (i_apply) begin
            r_mode   <= n_mode;
            r_depth  <= n_depth;
            r_line   <= n_line;
            r_src    <= n_src;
            r_paused <= n_paused;
        end
    end

    a_continue_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_apply && i_word.operation == OP_CONTINUE) |=> (r_mode == MODE_RUN && !r_paused))
        else $error("continue did not resume run mode");

    a_stop_pauses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_apply && o_rsp.stop) |=> r_paused)
        else $error("stop did not set the paused flag");

    a_unresolved_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.operation == OP_EVENT && !i_word.location_valid) |-> !o_rsp.stop)
        else $error("stop on an unresolved location");

endmodule
